// ===== design/hts_pkg.sv =====
`timescale 1ns / 1ps
package hts_pkg;

  // Port widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_W      = 8;
  localparam int HEIGHT_W   = 13;

  // Default store side
  localparam int MAX_SIDE_DEF = 256;

  // Operation codes carried in in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Reset value of tiles_per_side
  localparam logic [7:0] TILES_RESET = 8'd255;

  // Rounding and scaling: floor((H + 5) / 10) - 2560, divide by reciprocal
  localparam int ROUND_BIAS    = 5;
  localparam int RECIP_10      = 52429;  // ceil(2^19 / 10)
  localparam int RECIP_SHIFT   = 19;
  localparam int HEIGHT_OFFSET = 2560;
  localparam int ONE_Q8        = 256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_RDC,
    S_MAC,
    S_DIV
  } state_t;

  // Control for the shared arithmetic unit
  typedef struct packed {
    logic load_base;  // take base corner, acc = base * 256
    logic mac;        // acc += (rd - base) * factor
    logic fin;        // multiplier used for the divide by ten
  } arith_ctl_t;

endpackage

// ===== design/hts_arith.sv =====
`timescale 1ns / 1ps
module hts_arith (
  input  logic                              clk,
  input  hts_pkg::arith_ctl_t               ctl,
  input  logic [7:0]                        rd_data,
  input  logic [8:0]                        factor,
  output logic signed [hts_pkg::HEIGHT_W-1:0] height
);
  import hts_pkg::*;

  logic [7:0]          base_r;
  logic signed [17:0]  acc_r, acc_nxt;
  logic signed [8:0]   delta;
  logic signed [17:0]  mul_a, mul_b;
  logic signed [35:0]  prod;
  logic [16:0]         acc_pos;
  logic [16:0]         rounded;
  logic [12:0]         quot;
  logic [13:0]         diff;

  assign delta   = $signed({1'b0, rd_data}) - $signed({1'b0, base_r});
  assign acc_pos = acc_r[17] ? 17'd0 : acc_r[16:0];
  assign rounded = acc_pos + 17'(ROUND_BIAS);

  // One shared multiplier: interpolation steps, then the reciprocal of ten
  always_comb begin
    if (ctl.fin) begin
      mul_a = $signed({1'b0, rounded});
      mul_b = 18'(RECIP_10);
    end else begin
      mul_a = {{9{delta[8]}}, delta};
      mul_b = $signed({9'd0, factor});
    end
  end

  assign prod = mul_a * mul_b;
  assign quot = prod[RECIP_SHIFT+12:RECIP_SHIFT];
  assign diff = {1'b0, quot} - 14'(HEIGHT_OFFSET);
  assign height = $signed(diff[12:0]);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load_base) begin
      acc_nxt = $signed({2'b00, rd_data, 8'd0});
    end else if (ctl.mac) begin
      acc_nxt = acc_r + prod[17:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.load_base) begin
      base_r <= rd_data;
    end
  end

endmodule

// ===== design/heightmap_triangle_sample_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                          Contents (low bit first)
// in_       in   in_tvalid/in_tready/in_tdata/    tdata: grid_col, grid_row, sample_byte,
//                in_tuser                         query_x, query_z; tuser: operation
// out_      out  out_tvalid/out_tready/out_tdata/ tdata: height_q8 (+3 zero bits);
//                out_tuser                        tuser: in_range
// cfg_      in   cfg_we/cfg_wdata                 tiles_per_side
//
// A write transaction is taken without leaving idle; the block is ready again next cycle.
// A query on the grid steps through the states RDA, RDB, RDC, MAC and DIV, then
// returns to idle; its result is registered as DIV ends. The three corner samples
// come one per cycle from the height store, and one shared multiplier
// does both interpolation steps and the divide by ten. A query off the grid goes
// straight to DIV, and its result is registered as that state ends.
// Reset clears control and sets tiles_per_side to 255; the height store is not
// cleared. A stalled result holds the last step until out_tready frees the slot.
module heightmap_triangle_sample_unit #(
  parameter int MAX_SIDE = hts_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // grid_col, grid_row, sample_byte, query_x, query_z
  input  logic [hts_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,  // operation
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // height_q8, zero pad
  output logic [hts_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser, // in_range
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [hts_pkg::CFG_W-1:0]        cfg_wdata
);
  import hts_pkg::*;

  localparam int SW     = $clog2(MAX_SIDE);
  localparam int ADDR_W = 2 * SW;
  localparam int DEPTH  = 1 << ADDR_W;

  // Map a vertex to its store address: row in the high bits, column in the low
  function automatic logic [ADDR_W-1:0] vaddr(logic [8:0] c, logic [8:0] r);
    logic [31:0] c32;
    logic [31:0] r32;
    c32 = 32'(c);
    r32 = 32'(r);
    return {r32[SW-1:0], c32[SW-1:0]};
  endfunction

  // Input fields
  logic [7:0]  grid_col, grid_row, sample_byte;
  logic [15:0] query_x, query_z;

  assign grid_col    = in_tdata[7:0];
  assign grid_row    = in_tdata[15:8];
  assign sample_byte = in_tdata[23:16];
  assign query_x     = in_tdata[39:24];
  assign query_z     = in_tdata[55:40];

  state_t state_r, state_nxt;

  logic [7:0] tiles_r;
  logic [7:0] tiles_eff;
  logic [7:0] cx_r, cz_r, fx_r, fz_r;
  logic       upper_r, oor_r;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic       wr_en;
  logic [ADDR_W-1:0] wr_addr;

  arith_ctl_t ctl;
  logic [8:0] factor;
  logic signed [HEIGHT_W-1:0] height;

  logic [HEIGHT_W-1:0] out_height_r;
  logic                out_range_r, out_valid_r;

  logic in_acc, query_acc, out_free, off_grid;
  logic [8:0] cx0, cx1, cz0, cz1;

  assign in_acc    = in_tvalid && in_tready;
  assign query_acc = in_acc && (in_tuser == OP_QUERY);
  assign out_free  = !out_valid_r || out_tready;

  // Limit the tile count to what the store holds
  assign tiles_eff = ({24'd0, tiles_r} > 32'(MAX_SIDE - 1)) ? 8'(MAX_SIDE - 1) : tiles_r;
  assign off_grid  = (query_x[15:8] >= tiles_eff) || (query_z[15:8] >= tiles_eff);

  assign cx0 = {1'b0, cx_r};
  assign cz0 = {1'b0, cz_r};
  assign cx1 = cx0 + 9'd1;
  assign cz1 = cz0 + 9'd1;

  // Drop writes that fall outside the store
  assign wr_en   = in_acc && (in_tuser == OP_WRITE)
                   && ({24'd0, grid_col} < 32'(MAX_SIDE))
                   && ({24'd0, grid_row} < 32'(MAX_SIDE));
  assign wr_addr = vaddr({1'b0, grid_col}, {1'b0, grid_row});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sample_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Configuration and query capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_r <= TILES_RESET;
    end else if (cfg_we) begin
      tiles_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      cx_r    <= query_x[15:8];
      cz_r    <= query_z[15:8];
      fx_r    <= query_x[7:0];
      fz_r    <= query_z[7:0];
      upper_r <= ({1'b0, query_x[7:0]} + {1'b0, query_z[7:0]}) >= 9'(ONE_Q8);
      oor_r   <= off_grid;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (query_acc) state_nxt = off_grid ? S_DIV : S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_RDC;
      S_RDC:  state_nxt = S_MAC;
      S_MAC:  state_nxt = S_DIV;
      S_DIV:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: store reads, shared unit control, factor select
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = vaddr(cx0, cz0);
    ctl       = '0;
    factor    = 9'd0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_RDA: begin
        rd_en   = 1'b1;
        rd_addr = upper_r ? vaddr(cx1, cz1) : vaddr(cx0, cz0);
      end
      S_RDB: begin
        rd_en         = 1'b1;
        rd_addr       = vaddr(cx0, cz1);
        ctl.load_base = 1'b1;
      end
      S_RDC: begin
        rd_en   = 1'b1;
        rd_addr = vaddr(cx1, cz0);
        ctl.mac = 1'b1;
        factor  = upper_r ? 9'(ONE_Q8) - {1'b0, fx_r} : {1'b0, fz_r};
      end
      S_MAC: begin
        ctl.mac = 1'b1;
        factor  = upper_r ? 9'(ONE_Q8) - {1'b0, fz_r} : {1'b0, fx_r};
      end
      S_DIV:   ctl.fin = 1'b1;
      default: ctl     = '0;
    endcase
  end

  hts_arith u_arith (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data_r),
    .factor  (factor),
    .height  (height)
  );

  // Result register: load when the last step runs and the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DIV && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && out_free) begin
      out_height_r <= oor_r ? '0 : height;
      out_range_r  <= !oor_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_height_r};
  assign out_tuser  = out_range_r;

  // A result appears only after the final step
  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DIV)
    else $error("result loaded outside final step");

  // Off-grid results carry zero height
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_range_r |-> out_height_r == '0)
    else $error("off-grid result with non-zero height");

  // A query takes the block busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> !in_tready)
    else $error("ready straight after a query");

  // Held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_height_r))
    else $error("stalled result changed");

endmodule

// ===== test/heightmap_height_checker.sv =====
`timescale 1ns / 1ps
module heightmap_height_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hts_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [hts_pkg::CFG_W-1:0]      cfg_wdata,
  output int                             mismatch_count,
  output int                             pending_heights
);
  import hts_pkg::*;

  localparam int SIDE = MAX_SIDE_DEF;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height_q8;
    logic                in_range;
  } height_result_t;

  height_result_t expected_heights[$];
  logic [7:0]     sample_store [0:SIDE*SIDE-1];
  logic [7:0]     tile_count;

  function automatic int vertex_height(int col, int row);
    if (col >= SIDE || row >= SIDE)
      return 0;
    return int'(sample_store[row * SIDE + col]);
  endfunction

  // Triangle interpolation in exact raw*256, then round to raw/10 - 10 in Q8
  function automatic height_result_t predict_height(logic [15:0] qx, logic [15:0] qz);
    height_result_t r;
    int usable;
    int cx, cz, fx, fz;
    int h0, h1, h2, h3, acc;
    usable = int'(tile_count);
    if (usable > SIDE - 1)
      usable = SIDE - 1;
    r.height_q8 = '0;
    r.in_range  = 1'b0;
    if (int'(qx) >= usable * 256 || int'(qz) >= usable * 256)
      return r;
    cx = int'(qx[15:8]);
    cz = int'(qz[15:8]);
    fx = int'(qx[7:0]);
    fz = int'(qz[7:0]);
    h1 = vertex_height(cx, cz + 1);
    h2 = vertex_height(cx + 1, cz);
    if (fx + fz < 256) begin
      h0  = vertex_height(cx, cz);
      acc = h0 * 256 + (h1 - h0) * fz + (h2 - h0) * fx;
    end else begin
      h3  = vertex_height(cx + 1, cz + 1);
      acc = h3 * 256 + (h1 - h3) * (256 - fx) + (h2 - h3) * (256 - fz);
    end
    if (acc < 0)
      acc = 0;
    r.height_q8 = HEIGHT_W'((acc + 5) / 10 - 2560);
    r.in_range  = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    height_result_t want;
    if (!rst_n) begin
      tile_count = TILES_RESET;
      expected_heights.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_heights.size() == 0) begin
          $display("%0t: unexpected result, expected none, got height_q8 %0d in_range %0b",
                   $time, $signed(out_tdata[HEIGHT_W-1:0]), out_tuser);
          mismatch_count++;
        end else begin
          want = expected_heights.pop_front();
          if (out_tdata[HEIGHT_W-1:0] !== want.height_q8) begin
            $display("%0t: height_q8 expected %0d got %0d", $time,
                     $signed(want.height_q8), $signed(out_tdata[HEIGHT_W-1:0]));
            mismatch_count++;
          end
          if (out_tuser !== want.in_range) begin
            $display("%0t: in_range expected %0b got %0b", $time, want.in_range, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE)
          sample_store[int'(in_tdata[15:8]) * SIDE + int'(in_tdata[7:0])] = in_tdata[23:16];
        else
          expected_heights.insert(expected_heights.size(),
                                  predict_height(in_tdata[39:24], in_tdata[55:40]));
      end
      if (cfg_we)
        tile_count = cfg_wdata;
    end
    pending_heights = expected_heights.size();
  end

endmodule

// ===== test/heightmap_triangle_sample_unit_test.sv =====
`timescale 1ns / 1ps
module heightmap_triangle_sample_unit_test;
  import hts_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASE_ITEMS     = 140;

  logic                  clk;
  logic                  rst_n;
  // grid_col, grid_row, sample_byte, query_x, query_z (low bit first)
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;   // operation
  logic                  in_tvalid;
  logic                  in_tready;
  // height_q8, zero pad (low bit first)
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;  // in_range
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;

  int mismatch_count;
  int pending_heights;

  // Traffic shaping shared between the stimulus and the receiver process
  int gap_pct;
  int stall_pct;
  bit hold_off_req;

  // Stimulus-side view of the block: current tile count and which vertices hold data
  int tiles_now;
  int items_sent;
  bit vertex_written [0:MAX_SIDE_DEF*MAX_SIDE_DEF-1];
  int cycle_count;

  heightmap_triangle_sample_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  heightmap_height_checker height_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_heights (pending_heights)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("heightmap_triangle_sample_unit_test: FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when asked for.
  // The hold-off is counted here so the sender keeps offering transactions
  // and the block fills up behind the stalled result.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic set_traffic(int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 77; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 77; end
      default: begin gap_pct = 26; stall_pct = 26; end
    endcase
  endtask

  // Offer one transaction and hold it until the block takes it. Valid is left
  // high afterwards; it drops when the next call decides to idle or when wait_for_results runs.
  task automatic push_transaction(logic op, logic [7:0] col, logic [7:0] row,
                                  logic [7:0] sample, logic [15:0] qx, logic [15:0] qz);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_tdata  <= {qz, qx, sample, row, col};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_sample(int col, int row, logic [7:0] sample);
    vertex_written[row * MAX_SIDE_DEF + col] = 1'b1;
    push_transaction(OP_WRITE, col[7:0], row[7:0], sample, '0, '0);
  endtask

  // Query a point; on the grid, fill in any corner of its cell never written
  // first so that no read touches an empty vertex.
  task automatic query_point(logic [15:0] qx, logic [15:0] qz);
    int cx, cz;
    cx = int'(qx[15:8]);
    cz = int'(qz[15:8]);
    if (int'(qx) < tiles_now * 256 && int'(qz) < tiles_now * 256) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!vertex_written[(cz + dz) * MAX_SIDE_DEF + cx + dx])
            write_sample(cx + dx, cz + dz, 8'($urandom_range(0, 255)));
        end
      end
    end
    push_transaction(OP_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), qx, qz);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_for_results(int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_heights != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic program_tiles(int tiles);
    wait_for_results(SETTLE_CYCLES);
    cfg_wdata <= tiles[7:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tiles_now = tiles;
  endtask

  task automatic random_item();
    int off_edge, span, pick;
    logic [15:0] qx, qz;
    if ($urandom_range(0, 99) < 35) begin
      write_sample($urandom_range(0, 255), $urandom_range(0, 255), 8'($urandom_range(0, 255)));
    end else if (tiles_now == 0 || $urandom_range(0, 99) < 15) begin
      // Off the grid: push one or both coordinates past the far edge
      off_edge = tiles_now * 256;
      qx = 16'($urandom_range(0, 65535));
      qz = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 2);
      if (pick != 1)
        qx = 16'($urandom_range(off_edge, 65535));
      if (pick != 0)
        qz = 16'($urandom_range(off_edge, 65535));
      query_point(qx, qz);
    end else begin
      // Mostly stay in a small corner so written cells get reused
      span = tiles_now;
      if ($urandom_range(0, 99) < 60 && span > 6)
        span = 6;
      qx = {8'($urandom_range(0, span - 1)), 8'($urandom_range(0, 255))};
      qz = {8'($urandom_range(0, span - 1)), 8'($urandom_range(0, 255))};
      query_point(qx, qz);
    end
  endtask

  initial begin
    int tiles_plan [8];
    int phase_end;

    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= OP_WRITE;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    hold_off_req = 1'b0;
    items_sent   = 0;
    tiles_now    = int'(TILES_RESET);
    set_traffic(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme samples around the first cell, both triangles and the
    // diagonal seam either side of fx+fz = 1
    write_sample(0, 0, 8'd0);
    write_sample(1, 0, 8'd255);
    write_sample(0, 1, 8'd255);
    write_sample(1, 1, 8'd0);
    query_point(16'h0000, 16'h0000);
    query_point(16'h00FF, 16'h0000);
    query_point(16'h0080, 16'h007F);
    query_point(16'h0080, 16'h0080);
    query_point(16'h00FF, 16'h00FF);

    // Far corner of the largest grid at full height
    write_sample(254, 254, 8'd255);
    write_sample(255, 254, 8'd255);
    write_sample(254, 255, 8'd255);
    write_sample(255, 255, 8'd255);
    query_point(16'hFEFF, 16'hFEFF);
    query_point(16'hFE00, 16'hFE00);

    // Points just past and well past the edge
    query_point(16'hFF00, 16'h0000);
    query_point(16'h0000, 16'hFFFF);
    query_point(16'hFFFF, 16'hFFFF);

    // Single-tile grid, then zero tiles where every query is off the grid
    program_tiles(1);
    query_point(16'h00FF, 16'h00FF);
    query_point(16'h0100, 16'h0000);
    program_tiles(0);
    query_point(16'h0000, 16'h0000);

    // Random phases over several grid sizes and traffic patterns
    tiles_plan = '{255, 4, 1, 255, 32, 0, 2, $urandom_range(1, 255)};
    for (int phase = 0; phase < 8; phase++) begin
      program_tiles(tiles_plan[phase]);
      set_traffic(phase % 4);
      if (phase == 4)
        hold_off_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        random_item();
        // Let the pipeline empty once mid-phase
        if (phase == 1 && items_sent == phase_end - PHASE_ITEMS / 2)
          wait_for_results(0);
      end
    end

    wait_for_results(20);
    if (mismatch_count == 0)
      $display("heightmap_triangle_sample_unit_test: PASS");
    else
      $display("heightmap_triangle_sample_unit_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/hts_pkg.sv
design/hts_arith.sv
design/heightmap_triangle_sample_unit.sv
test/heightmap_height_checker.sv
test/heightmap_triangle_sample_unit_test.sv
